[rtl/plsi_pkg.sv]
`timescale 1ns / 1ps

package plsi_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int OP_W        = 3;
  localparam int POS_W       = 5;
  localparam int CNT_W       = 5;
  localparam int SLOT_W      = $clog2(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_ERASE     = 3'd1,
    OP_RETRIEVE  = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_ORDERED   = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    K_HOLD,
    K_INS_POS,
    K_INS_ORD,
    K_ERASE,
    K_WRITE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

[rtl/plsi_cell.sv]
`timescale 1ns / 1ps

module plsi_cell (
  input  logic                             clk,
  input  plsi_pkg::cell_ctl_t              ctl,
  input  logic [plsi_pkg::SLOT_W-1:0]      slot,
  input  logic [plsi_pkg::VALUE_WIDTH-1:0] value,
  input  logic [plsi_pkg::VALUE_WIDTH-1:0] left_val,
  input  logic [plsi_pkg::VALUE_WIDTH-1:0] right_val,
  input  logic                             left_ge,
  input  logic                             seen_in,
  output logic [plsi_pkg::VALUE_WIDTH-1:0] val,
  output logic                             ge,
  output logic                             seen_out
);
  import plsi_pkg::*;

  logic [VALUE_WIDTH-1:0] val_next;
  logic [CNT_W-1:0]       slot_ext;
  logic                   le;
  logic                   cand;

  assign slot_ext = CNT_W'(slot);
  assign ge       = (val >= value);
  assign le       = (value >= val);
  assign seen_out = seen_in | cand;

  // cand: this cell is the insertion slot; seen_in: slot lies to the left
  always_comb begin
    cand = 1'b0;
    case (ctl.kind)
      K_INS_POS: cand = (slot_ext == ctl.idx);
      K_INS_ORD: begin
        if (slot_ext == ctl.count) begin
          cand = 1'b1;
        end else if (slot_ext == '0) begin
          cand = !ge;
        end else begin
          cand = left_ge && le && (slot_ext < ctl.count);
        end
      end
      default: cand = 1'b0;
    endcase
  end

  always_comb begin
    val_next = val;
    case (ctl.kind)
      K_INS_POS, K_INS_ORD: begin
        if (seen_in) begin
          val_next = left_val;
        end else if (cand) begin
          val_next = value;
        end
      end
      K_ERASE: begin
        if (slot_ext >= ctl.idx) begin
          val_next = right_val;
        end
      end
      K_WRITE: begin
        if (slot_ext == ctl.idx) begin
          val_next = value;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

[rtl/plsi_chain.sv]
`timescale 1ns / 1ps

module plsi_chain (
  input  logic                                                 clk,
  input  plsi_pkg::cell_ctl_t                                  ctl,
  input  logic [plsi_pkg::VALUE_WIDTH-1:0]                     value,
  output logic [plsi_pkg::CAPACITY-1:0][plsi_pkg::VALUE_WIDTH-1:0] vals
);
  import plsi_pkg::*;

  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] seen;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;
    logic                   left_ge;
    logic                   seen_in;

    if (k == 0) begin : g_first
      assign left_val = '0;
      assign left_ge  = 1'b0;
      assign seen_in  = 1'b0;
    end else begin : g_mid
      assign left_val = vals[k-1];
      assign left_ge  = ge[k-1];
      assign seen_in  = seen[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_val = vals[k];
    end else begin : g_inner
      assign right_val = vals[k+1];
    end

    plsi_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (SLOT_W'(k)),
      .value     (value),
      .left_val  (left_val),
      .right_val (right_val),
      .left_ge   (left_ge),
      .seen_in   (seen_in),
      .val       (vals[k]),
      .ge        (ge[k]),
      .seen_out  (seen[k])
    );
  end

endmodule

[rtl/positional_list_with_sorted_insert.sv]
`timescale 1ns / 1ps
// Bounded positional list, up to 16 entries, 1-based positions.
// Request channel: req_valid / req_stall with operation, position, value.
//   An item is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall with ok, read_value, length.
//   Every request item gives exactly one response item, in order.
// Throughput: one item per cycle while req_stall is low. All list operations, including the ordered
//   insert, finish in the cycle of acceptance: a row of cells, one per entry,
//   compares against the new value and shifts left or right in parallel.
// The response is registered in the output register, or in the skid register if that one is stalled.
// A two-deep response stage (output register plus skid register) lets one
//   more request enter while a response is stalled; req_stall rises only when
//   both are full, and stays high until rsp_stall drops.
// Reset (rst, synchronous): list length goes to zero and both response
//   registers empty. Entry contents are not cleared; only written entries
//   are ever read.
module positional_list_with_sorted_insert (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [plsi_pkg::OP_W-1:0]        operation,
  input  logic [plsi_pkg::POS_W-1:0]       position,
  input  logic [plsi_pkg::VALUE_WIDTH-1:0] value,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             ok,
  output logic [plsi_pkg::VALUE_WIDTH-1:0] read_value,
  output logic [plsi_pkg::CNT_W-1:0]       length
);
  import plsi_pkg::*;

  logic [CNT_W-1:0]                      count;
  logic [CNT_W-1:0]                      count_next;
  logic [CAPACITY-1:0][VALUE_WIDTH-1:0]  vals;
  cell_ctl_t                             ctl;
  kind_t                                 kind;
  logic                                  accept;
  logic                                  ok_c;
  logic [VALUE_WIDTH-1:0]                rd_c;
  logic [CNT_W-1:0]                      idx;
  logic                                  in_list;
  logic                                  ins_pos_ok;
  logic                                  not_full;

  logic                                  skid_valid;
  logic                                  skid_ok;
  logic [VALUE_WIDTH-1:0]                skid_rd;
  logic [CNT_W-1:0]                      skid_len;

  assign req_stall  = skid_valid;
  assign accept     = req_valid && !req_stall;
  assign idx        = CNT_W'(position) - 1'b1;
  assign in_list    = (position != '0) && (CNT_W'(position) <= count);
  assign ins_pos_ok = (position != '0) &&
                      ({1'b0, CNT_W'(position)} <= ({1'b0, count} + 1'b1));
  assign not_full   = (count < CNT_W'(CAPACITY));

  always_comb begin
    ok_c       = 1'b0;
    rd_c       = '0;
    kind       = K_HOLD;
    count_next = count;
    case (op_t'(operation))
      OP_INSERT: begin
        if (ins_pos_ok && not_full) begin
          ok_c       = 1'b1;
          kind       = K_INS_POS;
          count_next = count + 1'b1;
        end
      end
      OP_ERASE: begin
        if (in_list) begin
          ok_c       = 1'b1;
          kind       = K_ERASE;
          count_next = count - 1'b1;
        end
      end
      OP_RETRIEVE: begin
        if (in_list) begin
          ok_c = 1'b1;
          rd_c = vals[idx[SLOT_W-1:0]];
        end
      end
      OP_OVERWRITE: begin
        if (in_list) begin
          ok_c = 1'b1;
          kind = K_WRITE;
        end
      end
      OP_ORDERED: begin
        if (not_full) begin
          ok_c       = 1'b1;
          kind       = K_INS_ORD;
          count_next = count + 1'b1;
        end
      end
      OP_CLEAR: begin
        ok_c       = 1'b1;
        count_next = '0;
      end
      default: ok_c = 1'b0;
    endcase
  end

  always_comb begin
    ctl.kind  = accept ? kind : K_HOLD;
    ctl.idx   = idx;
    ctl.count = count;
  end

  plsi_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .value (value),
    .vals  (vals)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_valid && !rsp_stall) begin
      if (skid_valid) begin
        ok         <= skid_ok;
        read_value <= skid_rd;
        length     <= skid_len;
        skid_valid <= 1'b0;
      end else if (accept) begin
        ok         <= ok_c;
        read_value <= rd_c;
        length     <= count_next;
      end else begin
        rsp_valid <= 1'b0;
      end
    end else if (!rsp_valid) begin
      rsp_valid <= accept;
      if (accept) begin
        ok         <= ok_c;
        read_value <= rd_c;
        length     <= count_next;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_ok    <= ok_c;
      skid_rd    <= rd_c;
      skid_len   <= count_next;
    end
  end

endmodule

[rtl/plsi_checker.sv]
`timescale 1ns / 1ps

module plsi_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_stall,
  input logic                             rsp_valid,
  input logic                             rsp_stall,
  input logic                             ok,
  input logic [plsi_pkg::VALUE_WIDTH-1:0] read_value,
  input logic [plsi_pkg::CNT_W-1:0]       length
);
  import plsi_pkg::*;

  // no response right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stall only when a response is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no response pending");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (length <= CNT_W'(CAPACITY)))
    else $error("length beyond capacity");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> (read_value == '0))
    else $error("rejected item carries read data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(length) && $stable(ok)))
    else $error("stalled response changed");

endmodule

bind positional_list_with_sorted_insert plsi_checker u_plsi_checker (.*);
